[design/salru_pkg.sv]
// Shared types and constants for the set-associative cache tag and LRU control block.
// No dependencies; every other design file but salru_row_ram imports this package.
`default_nettype none

package salru_pkg;

    // Fixed widths of the request and result fields.
    localparam int IN_ADDR_W  = 24;
    localparam int OUT_ADDR_W = 24;
    localparam int WAY_OUT_W  = 2;

    // Request operation codes.
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_FILL   = 1'b1
    } op_t;

    // Result of one request, as it leaves the row update logic.
    typedef struct packed {
        logic                  hit;
        logic [WAY_OUT_W-1:0]  way;
        logic                  writeback;
        logic [OUT_ADDR_W-1:0] victim_block_addr;
    } salru_result_t;

endpackage

`default_nettype wire

[design/set_assoc_cache_lru_tags_core.sv]
// Set-associative cache tag store with counter-based LRU ranks, returning one result per request.
// A request passes one row read and one update and write-back of the row memory when NUM_SETS
// is a power of two; otherwise the set and tag first come out of a two-stage reciprocal divider.
// A result that is not taken holds the next request at its update.
// Requests are handled one at a time, so a row write always lands before the next row read.
// After reset the block runs a clearing pass over every row of the row memory, with
// s_ready low, before it takes the first request. The way output addresses an external data array.
`default_nettype none

module set_assoc_cache_lru_tags_core import salru_pkg::*; #(
    parameter int NUM_SETS        = 64,
    parameter int WAYS            = 4,
    parameter int BLOCK_ADDR_BITS = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [IN_ADDR_W-1:0]  s_block_addr,
    input  wire logic                  s_fill_dirty,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_hit,
    output logic [WAY_OUT_W-1:0]       m_way,
    output logic                       m_writeback,
    output logic [OUT_ADDR_W-1:0]      m_victim_block_addr
);

    localparam int ADDR_W = (BLOCK_ADDR_BITS < IN_ADDR_W) ? BLOCK_ADDR_BITS : IN_ADDR_W;
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int TAG_RAW = $clog2(((1 << ADDR_W) - 1) / NUM_SETS + 1);
    localparam int TAG_W  = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int ROW_W  = WAYS * (TAG_W + RANK_W + 2);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_UPD
    } state_t;

    state_t             state_reg;
    logic [SET_W-1:0]   clr_reg;
    op_t                op_reg;
    logic               fd_reg;
    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               m_valid_reg;
    salru_result_t      result_reg;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic               split_valid;
    logic [SET_W-1:0]   split_set;
    logic [TAG_W-1:0]   split_tag;

    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [ROW_W-1:0]   ram_rdata;

    logic [WAYS-1:0]              rd_valid;
    logic [WAYS-1:0]              rd_dirty;
    logic [WAYS-1:0][RANK_W-1:0]  rd_rank;
    logic [WAYS-1:0][TAG_W-1:0]   rd_tag;
    logic [WAYS-1:0]              wr_valid;
    logic [WAYS-1:0]              wr_dirty;
    logic [WAYS-1:0][RANK_W-1:0]  wr_rank;
    logic [WAYS-1:0][TAG_W-1:0]   wr_tag;
    logic                         row_we;
    salru_result_t                upd_result;

    // Handshake qualifiers.
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_UPD) && out_free;

    // Address split into set and tag.
    salru_addr_split #(
        .NUM_SETS (NUM_SETS),
        .ADDR_W   (ADDR_W),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W)
    ) u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_addr   (s_block_addr[ADDR_W-1:0]),
        .out_valid (split_valid),
        .out_set   (split_set),
        .out_tag   (split_tag)
    );

    // Row memory: the clearing pass writes zero rows, an update writes the modified row.
    assign ram_we    = (state_reg == ST_CLEAR) || (commit && row_we);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : set_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : {wr_valid, wr_dirty, wr_rank, wr_tag};

    salru_row_ram #(
        .DEPTH (NUM_SETS),
        .WIDTH (ROW_W),
        .AW    (SET_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (split_valid),
        .raddr (split_set),
        .rdata (ram_rdata)
    );

    assign {rd_valid, rd_dirty, rd_rank, rd_tag} = ram_rdata;

    // Lookup or fill applied to the row just read.
    salru_row_update #(
        .NUM_SETS (NUM_SETS),
        .WAYS     (WAYS),
        .ADDR_W   (ADDR_W),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W),
        .RANK_W   (RANK_W),
        .WAY_W    (WAY_W),
        .CNT_W    (CNT_W)
    ) u_update (
        .op         (op_reg),
        .fill_dirty (fd_reg),
        .req_tag    (tag_reg),
        .req_set    (set_reg),
        .row_valid  (rd_valid),
        .row_dirty  (rd_dirty),
        .row_rank   (rd_rank),
        .row_tag    (rd_tag),
        .new_valid  (wr_valid),
        .new_dirty  (wr_dirty),
        .new_rank   (wr_rank),
        .new_tag    (wr_tag),
        .row_we     (row_we),
        .result     (upd_result)
    );

    // Sequencer: clearing pass, request capture, row update and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + SET_W'(1);
                    if (clr_reg == SET_W'(NUM_SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg <= op_t'(s_op);
                        fd_reg <= s_fill_dirty;
                        if (split_valid) begin
                            set_reg   <= split_set;
                            tag_reg   <= split_tag;
                            state_reg <= ST_UPD;
                        end else begin
                            state_reg <= ST_SPLIT;
                        end
                    end
                end
                ST_SPLIT: begin
                    if (split_valid) begin
                        set_reg   <= split_set;
                        tag_reg   <= split_tag;
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (out_free) begin
                        result_reg <= upd_result;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result ports.
    assign m_valid             = m_valid_reg;
    assign m_hit               = result_reg.hit;
    assign m_way               = result_reg.way;
    assign m_writeback         = result_reg.writeback;
    assign m_victim_block_addr = result_reg.victim_block_addr;

endmodule

`default_nettype wire

[design/salru_addr_split.sv]
// Splits a block address into set index (address modulo NUM_SETS) and tag (quotient).
// Depends on salru_pkg. Combinational for a power-of-two set count, registered otherwise.
`default_nettype none

module salru_addr_split import salru_pkg::*; #(
    parameter int NUM_SETS = 64,
    parameter int ADDR_W   = 24,
    parameter int SET_W    = 6,
    parameter int TAG_W    = 18
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [ADDR_W-1:0] in_addr,
    output logic                   out_valid,
    output logic [SET_W-1:0]       out_set,
    output logic [TAG_W-1:0]       out_tag
);

    localparam bit IS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_pow2
            localparam int SHIFT_BITS = $clog2(NUM_SETS);

            logic [ADDR_W+SET_W-1:0] addr_ext;
            logic [ADDR_W+SET_W-1:0] tag_full;

            // A power-of-two divisor is a plain bit split.
            assign addr_ext  = {{SET_W{1'b0}}, in_addr};
            assign tag_full  = addr_ext >> SHIFT_BITS;
            assign out_tag   = tag_full[TAG_W-1:0];
            assign out_set   = SET_W'(addr_ext & (ADDR_W + SET_W)'(NUM_SETS - 1));
            assign out_valid = in_valid;
        end else begin : g_recip
            localparam int RECIP = (1 << ADDR_W) / NUM_SETS;
            localparam int PW    = 2 * ADDR_W + 1;
            localparam int XW    = ADDR_W + SET_W + 1;

            logic [PW-1:0]     prod;
            logic [ADDR_W-1:0] addr1_reg;
            logic [ADDR_W-1:0] q1_reg;
            logic              v1_reg;
            logic [XW-1:0]     qn;
            logic [XW-1:0]     rem_raw;
            logic [XW-1:0]     rem_fix;
            logic [ADDR_W-1:0] q_fix;
            logic              v2_reg;
            logic [SET_W-1:0]  set2_reg;
            logic [TAG_W-1:0]  tag2_reg;

            // Stage 1: quotient estimate by reciprocal multiply; it is exact or one low.
            assign prod = PW'(in_addr) * PW'(RECIP);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v1_reg <= 1'b0;
                    v2_reg <= 1'b0;
                end else begin
                    v1_reg    <= in_valid;
                    addr1_reg <= in_addr;
                    q1_reg    <= prod[2*ADDR_W-1:ADDR_W];
                    v2_reg    <= v1_reg;
                    set2_reg  <= rem_fix[SET_W-1:0];
                    tag2_reg  <= q_fix[TAG_W-1:0];
                end
            end

            // Stage 2: remainder from the estimate, with one correction step.
            always_comb begin
                qn      = XW'(q1_reg) * XW'(NUM_SETS);
                rem_raw = XW'(addr1_reg) - qn;
                if (rem_raw >= XW'(NUM_SETS)) begin
                    rem_fix = rem_raw - XW'(NUM_SETS);
                    q_fix   = q1_reg + ADDR_W'(1);
                end else begin
                    rem_fix = rem_raw;
                    q_fix   = q1_reg;
                end
            end

            assign out_valid = v2_reg;
            assign out_set   = set2_reg;
            assign out_tag   = tag2_reg;
        end
    endgenerate

endmodule

`default_nettype wire

[design/salru_row_ram.sv]
// Set row memory: one row per set holding tags, valid, dirty and rank bits of all ways.
// No dependencies. One write port, one read port with registered read data.
`default_nettype none

module salru_row_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 88,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Synchronous write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/salru_row_update.sv]
// Lookup and fill logic on one set row: tag match, way choice, LRU rank update, victim address.
// Depends on salru_pkg for the operation codes and the result struct.
`default_nettype none

module salru_row_update import salru_pkg::*; #(
    parameter int NUM_SETS = 64,
    parameter int WAYS     = 4,
    parameter int ADDR_W   = 24,
    parameter int SET_W    = 6,
    parameter int TAG_W    = 18,
    parameter int RANK_W   = 2,
    parameter int WAY_W    = 2,
    parameter int CNT_W    = 3
) (
    input  wire op_t                              op,
    input  wire logic                             fill_dirty,
    input  wire logic [TAG_W-1:0]                 req_tag,
    input  wire logic [SET_W-1:0]                 req_set,
    input  wire logic [WAYS-1:0]                  row_valid,
    input  wire logic [WAYS-1:0]                  row_dirty,
    input  wire logic [WAYS-1:0][RANK_W-1:0]      row_rank,
    input  wire logic [WAYS-1:0][TAG_W-1:0]       row_tag,
    output logic      [WAYS-1:0]                  new_valid,
    output logic      [WAYS-1:0]                  new_dirty,
    output logic      [WAYS-1:0][RANK_W-1:0]      new_rank,
    output logic      [WAYS-1:0][TAG_W-1:0]       new_tag,
    output logic                                  row_we,
    output salru_result_t                         result
);

    localparam int VW = ADDR_W + SET_W;

    logic [CNT_W-1:0] valid_cnt;
    logic             hit_any;
    logic [WAY_W-1:0] hit_w;
    logic             inv_any;
    logic [WAY_W-1:0] inv_w;
    logic [WAY_W-1:0] lru_w;
    logic [VW-1:0]    victim_full;

    // Per-way searches over the row; descending loops leave the lowest way selected.
    always_comb begin
        valid_cnt = '0;
        hit_any   = 1'b0;
        hit_w     = '0;
        inv_any   = 1'b0;
        inv_w     = '0;
        lru_w     = '0;
        for (int k = 0; k < WAYS; k++) begin
            valid_cnt = valid_cnt + CNT_W'(row_valid[k]);
        end
        for (int k = WAYS - 1; k >= 0; k--) begin
            if (row_valid[k] && (row_tag[k] == req_tag)) begin
                hit_any = 1'b1;
                hit_w   = WAY_W'(k);
            end
            if (!row_valid[k]) begin
                inv_any = 1'b1;
                inv_w   = WAY_W'(k);
            end
            if (row_rank[k] == '0) begin
                lru_w = WAY_W'(k);
            end
        end
    end

    // Block address of the least recent line, rebuilt from its tag and the set.
    assign victim_full = VW'(row_tag[lru_w]) * VW'(NUM_SETS) + VW'(req_set);

    // Row rewrite and result for the request.
    always_comb begin
        new_valid = row_valid;
        new_dirty = row_dirty;
        new_rank  = row_rank;
        new_tag   = row_tag;
        row_we    = 1'b0;
        result    = '0;
        if (op == OP_LOOKUP) begin
            // A hit becomes most recent; more recent valid ways move down by one.
            if (hit_any) begin
                row_we     = 1'b1;
                result.hit = 1'b1;
                result.way = WAY_OUT_W'(hit_w);
                for (int k = 0; k < WAYS; k++) begin
                    if (row_valid[k] && (WAY_W'(k) != hit_w) &&
                        (row_rank[k] > row_rank[hit_w])) begin
                        new_rank[k] = row_rank[k] - RANK_W'(1);
                    end
                end
                new_rank[hit_w] = RANK_W'(valid_cnt - CNT_W'(1));
            end
        end else begin
            row_we = 1'b1;
            if (inv_any) begin
                // A free way takes the line; other ranks stay as they are.
                new_tag[inv_w]   = req_tag;
                new_valid[inv_w] = 1'b1;
                new_dirty[inv_w] = fill_dirty;
                new_rank[inv_w]  = RANK_W'(valid_cnt);
                result.way       = WAY_OUT_W'(inv_w);
            end else begin
                // Full set: evict the least recent way and age all others.
                result.way       = WAY_OUT_W'(lru_w);
                result.writeback = row_dirty[lru_w];
                if (row_dirty[lru_w]) begin
                    result.victim_block_addr = OUT_ADDR_W'(victim_full[ADDR_W-1:0]);
                end
                for (int k = 0; k < WAYS; k++) begin
                    if (row_valid[k] && (WAY_W'(k) != lru_w) && (row_rank[k] != '0)) begin
                        new_rank[k] = row_rank[k] - RANK_W'(1);
                    end
                end
                new_tag[lru_w]   = req_tag;
                new_valid[lru_w] = 1'b1;
                new_dirty[lru_w] = fill_dirty;
                new_rank[lru_w]  = RANK_W'(WAYS - 1);
            end
        end
    end

endmodule

`default_nettype wire

[design/salru_checker.sv]
// Port-level checks for the cache tag block, with the bind that attaches them to the top level.
// Depends on salru_pkg and on set_assoc_cache_lru_tags_core.
`default_nettype none

module salru_checker import salru_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_hit,
    input wire logic [WAY_OUT_W-1:0]  m_way,
    input wire logic                  m_writeback,
    input wire logic [OUT_ADDR_W-1:0] m_victim_block_addr
);

    // A stalled result keeps its fields.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_way) &&
            $stable(m_writeback) && $stable(m_victim_block_addr))
        else $error("result changed while stalled");

    // Requests are handled one at a time.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

    // A result appears only after a request was in progress.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a request in flight");

    // A lookup hit never evicts.
    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_writeback)
        else $error("hit result carries a writeback");

    // Without a writeback the victim address is zero.
    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_writeback |-> (m_victim_block_addr == '0))
        else $error("victim address set without writeback");

endmodule

bind set_assoc_cache_lru_tags_core salru_checker u_salru_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_hit               (m_hit),
    .m_way               (m_way),
    .m_writeback         (m_writeback),
    .m_victim_block_addr (m_victim_block_addr)
);

`default_nettype wire

[dv/tb_set_assoc_cache_lru_tags_core.sv]
// Testbench for set_assoc_cache_lru_tags_core: directed and random lookup and fill requests,
// checked field by field against typed rows or a model of tags, flags and LRU ranks.
// Depends on salru_pkg and the core module only.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_tags_core import salru_pkg::*;;

    localparam int NUM_SETS        = 64;
    localparam int WAYS            = 4;
    localparam int BLOCK_ADDR_BITS = 24;
    localparam int SET_BITS        = 6;
    localparam int TAG_BITS        = BLOCK_ADDR_BITS - SET_BITS;
    localparam int RANDOM_REQUESTS = 800;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_CYCLES    = 16;
    localparam int DIRECTED_ROWS   = 22;

    // One row of the directed stimulus; typed rows carry their own expected result.
    typedef struct {
        op_t             op;
        logic [23:0]     addr;
        logic            dirty;
        bit              typed;
        salru_result_t   want;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    op_t                   s_op = OP_LOOKUP;
    logic [IN_ADDR_W-1:0]  s_block_addr = '0;
    logic                  s_fill_dirty = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_hit;
    logic [WAY_OUT_W-1:0]  m_way;
    logic                  m_writeback;
    logic [OUT_ADDR_W-1:0] m_victim_block_addr;

    // Model state of the tag array, one entry per line.
    logic [TAG_BITS-1:0] line_tag   [NUM_SETS][WAYS];
    logic                line_valid [NUM_SETS][WAYS];
    logic                line_dirty [NUM_SETS][WAYS];
    logic [1:0]          line_rank  [NUM_SETS][WAYS];

    salru_result_t pending_results [$];
    salru_result_t oldest_result;

    int fail_count      = 0;
    int lookup_count    = 0;
    int fill_count      = 0;
    int hit_count       = 0;
    int writeback_count = 0;
    int send_idle_pct   = 21;
    int recv_idle_pct   = 78;
    bit hold_off_wanted = 1'b0;
    bit hold_off_served = 1'b0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // After reset every lookup misses, whatever the dirty input says.
        '{OP_LOOKUP, 24'h000000, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'hFFFFFF, 1'b1, 1'b1, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        // First fills of the lowest and highest sets land in way 0.
        '{OP_FILL,   24'h000000, 1'b1, 1'b1, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_FILL,   24'hFFFFFF, 1'b1, 1'b1, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'hFFFFFF, 1'b0, 1'b1, '{1'b1, 2'd0, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'h000040, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        // Fill set 0 up to all four ways, then touch way 0.
        '{OP_FILL,   24'h000040, 1'b0, 1'b1, '{1'b0, 2'd1, 1'b0, 24'h000000}},
        '{OP_FILL,   24'h000080, 1'b1, 1'b1, '{1'b0, 2'd2, 1'b0, 24'h000000}},
        '{OP_FILL,   24'h0000C0, 1'b0, 1'b1, '{1'b0, 2'd3, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'h000000, 1'b0, 1'b1, '{1'b1, 2'd0, 1'b0, 24'h000000}},
        // Evictions from a full set: a clean victim, then a dirty one.
        '{OP_FILL,   24'h000100, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_FILL,   24'h000140, 1'b1, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'h000040, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'h0000C0, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        // A duplicate fill takes a free way; lookups still hit the lowest copy.
        '{OP_FILL,   24'hFFFFFF, 1'b0, 1'b1, '{1'b0, 2'd1, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'hFFFFFF, 1'b0, 1'b1, '{1'b1, 2'd0, 1'b0, 24'h000000}},
        // Fill the top set, then evict the duplicate and the dirty all-ones block.
        '{OP_FILL,   24'hFFFFBF, 1'b1, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_FILL,   24'h00003F, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_FILL,   24'h7FFFFF, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_FILL,   24'h3FFFFF, 1'b1, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'hFFFFFF, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}},
        '{OP_LOOKUP, 24'h7FFFFF, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0, 24'h000000}}
    };

    set_assoc_cache_lru_tags_core #(
        .NUM_SETS        (NUM_SETS),
        .WAYS            (WAYS),
        .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_block_addr        (s_block_addr),
        .s_fill_dirty        (s_fill_dirty),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_hit               (m_hit),
        .m_way               (m_way),
        .m_writeback         (m_writeback),
        .m_victim_block_addr (m_victim_block_addr)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Make one way of a set the most recent; optionally age the ways ranked above it.
    function automatic void make_most_recent(int set_idx, int way_idx, bit age_others);
        logic [1:0] own_rank;
        int         valid_ways;
        own_rank   = line_rank[set_idx][way_idx];
        valid_ways = 0;
        for (int k = 0; k < WAYS; k++) begin
            if (line_valid[set_idx][k]) begin
                valid_ways++;
                if (age_others && k != way_idx && line_rank[set_idx][k] > own_rank) begin
                    line_rank[set_idx][k]--;
                end
            end
        end
        line_rank[set_idx][way_idx] = 2'(valid_ways - 1);
    endfunction

    // Predict the result of one request and update the model tag array.
    function automatic salru_result_t predict_tag_access(op_t op, logic [23:0] addr,
                                                         logic dirty);
        salru_result_t       res;
        int                  set_idx;
        logic [TAG_BITS-1:0] tag;
        int                  picked;
        bit                  found;
        bit                  full_set;
        res      = '0;
        set_idx  = int'(addr[SET_BITS-1:0]);
        tag      = addr[BLOCK_ADDR_BITS-1:SET_BITS];
        picked   = 0;
        found    = 1'b0;
        full_set = 1'b0;
        if (op == OP_LOOKUP) begin
            for (int w = 0; w < WAYS; w++) begin
                if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
                    found  = 1'b1;
                    picked = w;
                end
            end
            if (found) begin
                res.hit = 1'b1;
                res.way = 2'(picked);
                make_most_recent(set_idx, picked, 1'b1);
            end
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !line_valid[set_idx][w]) begin
                    found  = 1'b1;
                    picked = w;
                end
            end
            // Full set: the first way of rank zero is the victim, way 0 if none.
            if (!found) begin
                full_set = 1'b1;
                for (int w = WAYS - 1; w >= 0; w--) begin
                    if (line_rank[set_idx][w] == 2'd0) picked = w;
                end
                if (line_dirty[set_idx][picked]) begin
                    res.writeback         = 1'b1;
                    res.victim_block_addr = {line_tag[set_idx][picked], addr[SET_BITS-1:0]};
                end
            end
            line_tag[set_idx][picked]   = tag;
            line_valid[set_idx][picked] = 1'b1;
            line_dirty[set_idx][picked] = dirty;
            line_rank[set_idx][picked]  = 2'd0;
            make_most_recent(set_idx, picked, full_set);
            res.way = 2'(picked);
        end
        return res;
    endfunction

    // Random block address: mostly a few busy sets and tags, some extremes and noise.
    function automatic logic [23:0] pick_block_addr();
        logic [TAG_BITS-1:0] tag;
        logic [SET_BITS-1:0] set_idx;
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: begin
                tag     = $urandom_range(1) ? '1 : '0;
                set_idx = SET_BITS'($urandom);
            end
            default: begin
                tag     = TAG_BITS'($urandom_range(5));
                set_idx = SET_BITS'($urandom_range(3));
            end
        endcase
        return {tag, set_idx};
    endfunction

    // Offer one request, hold it until it is taken, then record its expected result.
    task automatic send_request(op_t op, logic [23:0] addr, logic dirty, bit typed,
                                salru_result_t want);
        salru_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_block_addr <= addr;
        s_fill_dirty <= dirty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_tag_access(op, addr, dirty);
        pending_results.push_back(typed ? want : predicted);
        if (op == OP_LOOKUP) lookup_count++;
        else fill_count++;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_wanted && !hold_off_served) begin
                hold_off_served = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: hit=%0d way=%0d", m_hit, m_way);
                fail_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_hit !== oldest_result.hit) begin
                    $error("hit: expected %0d, got %0d", oldest_result.hit, m_hit);
                    fail_count++;
                end
                if (m_way !== oldest_result.way) begin
                    $error("way: expected %0d, got %0d", oldest_result.way, m_way);
                    fail_count++;
                end
                if (m_writeback !== oldest_result.writeback) begin
                    $error("writeback: expected %0d, got %0d",
                           oldest_result.writeback, m_writeback);
                    fail_count++;
                end
                if (m_victim_block_addr !== oldest_result.victim_block_addr) begin
                    $error("victim_block_addr: expected %h, got %h",
                           oldest_result.victim_block_addr, m_victim_block_addr);
                    fail_count++;
                end
                if (m_hit === 1'b1) hit_count++;
                if (m_writeback === 1'b1) writeback_count++;
            end
        end
    end

    // Stimulus: reset, directed table, three idling phases of random requests, drain.
    initial begin
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_rank[s][w]  = 2'd0;
            end
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].dirty,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 21;
            end
            // Last phase runs flat out and starts with a long result hold-off.
            if (n == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct   = 0;
                recv_idle_pct   = 0;
                hold_off_wanted = 1'b1;
            end
            send_request(($urandom_range(99) < 45) ? OP_FILL : OP_LOOKUP, pick_block_addr(),
                         1'($urandom), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d lookups and %0d fills through directed cases and three idling phases,",
                 lookup_count, fill_count);
        $display("including a %0d-cycle result hold-off; saw %0d hits and %0d dirty evictions.",
                 HOLD_OFF_CYCLES, hit_count, writeback_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $error("timeout with %0d results outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
